>>> hdl/gno_pkg.sv
// ----------------------------------------------------------------------------
// gno_pkg
// Shared constants, codes and stage types of the gradient noise octave block.
// ----------------------------------------------------------------------------
package gno_pkg;

   localparam int FRAC_BITS       = 16;
   localparam int INT_BITS        = 8;
   localparam int COORD_W         = INT_BITS + FRAC_BITS;
   localparam int ONE             = 1 << FRAC_BITS;
   localparam int TABLE_DEPTH     = 256;
   localparam int ADDR_W          = $clog2(TABLE_DEPTH);
   localparam int DATA_W          = 8;
   localparam int AMP_W           = FRAC_BITS + 1;
   localparam int FADE_W          = FRAC_BITS + 1;
   localparam int GRAD_W          = 20;
   localparam int OUT_W           = 20;
   localparam int COUNT_W         = 4;
   localparam int MAX_OCTAVES_DEF = 8;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 17;

   localparam logic [CSR_IDX_W-1:0] REG_OCTAVE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERSISTENCE  = 2'd1;

   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_1D    = 2'd1,
      MODE_2D    = 2'd2,
      MODE_3D    = 2'd3
   } mode_type;

   typedef struct packed {
      logic                 valid;
      logic                 zero;
      logic                 first;
      logic                 last;
      mode_type             mode;
      logic [INT_BITS-1:0]  ix;
      logic [INT_BITS-1:0]  iy;
      logic [INT_BITS-1:0]  iz;
      logic [FRAC_BITS-1:0] fx;
      logic [FRAC_BITS-1:0] fy;
      logic [FRAC_BITS-1:0] fz;
      logic [AMP_W-1:0]     amp;
   } op_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } wr_type;

   typedef struct packed {
      logic [1:0][DATA_W-1:0] h1;
      logic [3:0][DATA_W-1:0] h2;
      logic [7:0][DATA_W-1:0] h3;
   } hash_type;

endpackage

>>> hdl/gno_if.sv
// ----------------------------------------------------------------------------
// gno_if
// Valid/ready channels: sample requests, noise results, register writes.
// ----------------------------------------------------------------------------
interface gno_req_if;
   import gno_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          mode;
   logic [COORD_W-1:0]  coord_x;
   logic [COORD_W-1:0]  coord_y;
   logic [COORD_W-1:0]  coord_z;
   logic [ADDR_W-1:0]   table_index;
   logic [DATA_W-1:0]   table_value;

   modport source (output valid, mode, coord_x, coord_y, coord_z, table_index,
                   table_value, input ready);
   modport sink   (input valid, mode, coord_x, coord_y, coord_z, table_index,
                   table_value, output ready);
endinterface

interface gno_rsp_if;
   import gno_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] noise_value;

   modport source (output valid, noise_value, input ready);
   modport sink   (input valid, noise_value, output ready);
endinterface

interface gno_csr_if;
   import gno_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/gno_hash_ram.sv
// ----------------------------------------------------------------------------
// gno_hash_ram
// One copy of the hash table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module gno_hash_ram import gno_pkg::*; (
   input  logic                   clock,
   input  logic                   en,
   input  wr_type                 wr,
   input  logic [1:0][ADDR_W-1:0] rd_addr,
   output logic [1:0][DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [TABLE_DEPTH];
   logic [1:0][DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (en) begin
         rd_data_ff[0] <= mem[rd_addr[0]];
         rd_data_ff[1] <= mem[rd_addr[1]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/gno_issue.sv
// ----------------------------------------------------------------------------
// gno_issue
// Octave sequencer: takes a request, issues one octave per unstalled cycle
// with shifted coordinates and the running amplitude. Holds the registers.
// ----------------------------------------------------------------------------
module gno_issue import gno_pkg::*; #(
   parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      adv,
   input  logic      busy,
   gno_req_if.sink   req_chan,
   gno_csr_if.sink   csr_chan,
   output op_type    op0,
   output wr_type    wr
);

   localparam int OCT_W = $clog2(MAX_OCTAVES + 1);

   logic [COUNT_W-1:0] octave_count_ff;
   logic [AMP_W-1:0]   persistence_ff;
   logic               act_ff;
   logic               zero_ff;
   logic               first_ff;
   mode_type           mode_ff;
   logic [COORD_W-1:0] cx_ff, cy_ff, cz_ff;
   logic [AMP_W-1:0]   amp_ff;
   logic [OCT_W-1:0]   left_ff;

   logic                 last_c, take, free, is_write, accept, zero_in;
   logic [OCT_W-1:0]     n_c;
   logic [AMP_W-1:0]     pers_c, amp_in;
   logic [2*AMP_W-1:0]   amp_prod;

   assign last_c   = (left_ff == '0);
   assign take     = adv && act_ff;
   assign free     = !act_ff || last_c;
   assign is_write = (mode_type'(req_chan.mode) == MODE_WRITE);
   assign req_chan.ready = adv && free && (!is_write || (!act_ff && !busy));
   assign accept   = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign n_c = (32'(octave_count_ff) > MAX_OCTAVES) ? OCT_W'(MAX_OCTAVES)
                                                     : OCT_W'(octave_count_ff);
   assign pers_c   = (32'(persistence_ff) > ONE) ? AMP_W'(ONE) : persistence_ff;
   assign amp_prod = amp_ff * pers_c;
   assign amp_in   = amp_prod[FRAC_BITS +: AMP_W];
   assign zero_in  = is_write || (n_c == '0);

   assign wr.en   = accept && is_write;
   assign wr.addr = req_chan.table_index;
   assign wr.data = req_chan.table_value;

   always_comb begin
      op0.valid = act_ff;
      op0.zero  = zero_ff;
      op0.first = first_ff;
      op0.last  = last_c;
      op0.mode  = mode_ff;
      op0.ix    = cx_ff[COORD_W-1:FRAC_BITS];
      op0.iy    = cy_ff[COORD_W-1:FRAC_BITS];
      op0.iz    = cz_ff[COORD_W-1:FRAC_BITS];
      op0.fx    = cx_ff[FRAC_BITS-1:0];
      op0.fy    = cy_ff[FRAC_BITS-1:0];
      op0.fz    = cz_ff[FRAC_BITS-1:0];
      op0.amp   = amp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff          <= 1'b0;
         octave_count_ff <= COUNT_W'(1);
         persistence_ff  <= AMP_W'(32768);
      end else begin
         if (accept) begin
            act_ff <= 1'b1;
         end else if (take && last_c) begin
            act_ff <= 1'b0;
         end
         if (csr_chan.valid) begin
            case (csr_chan.index)
               REG_OCTAVE_COUNT: octave_count_ff <= csr_chan.data[COUNT_W-1:0];
               REG_PERSISTENCE:  persistence_ff  <= csr_chan.data[AMP_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= mode_type'(req_chan.mode);
         zero_ff  <= zero_in;
         first_ff <= 1'b1;
         cx_ff    <= req_chan.coord_x;
         cy_ff    <= req_chan.coord_y;
         cz_ff    <= req_chan.coord_z;
         amp_ff   <= AMP_W'(ONE);
         left_ff  <= zero_in ? '0 : n_c - OCT_W'(1);
      end else if (take && !last_c) begin
         first_ff <= 1'b0;
         cx_ff    <= {cx_ff[COORD_W-2:0], 1'b0};
         cy_ff    <= {cy_ff[COORD_W-2:0], 1'b0};
         cz_ff    <= {cz_ff[COORD_W-2:0], 1'b0};
         amp_ff   <= amp_in;
         left_ff  <= left_ff - OCT_W'(1);
      end
   end

   a_more_octaves: assert property (@(posedge clock) disable iff (reset)
      (take && !last_c) |=> (act_ff && !first_ff))
      else $error("item dropped before its last octave");

   a_write_single: assert property (@(posedge clock) disable iff (reset)
      wr.en |=> (op0.valid && op0.zero && op0.last))
      else $error("table write not issued as a single zero transaction");

   a_amp_range: assert property (@(posedge clock) disable iff (reset)
      act_ff |-> (32'(amp_ff) <= ONE))
      else $error("amplitude above one");

endmodule

>>> hdl/gno_hash.sv
// ----------------------------------------------------------------------------
// gno_hash
// Three-level lattice hashing through replicated table copies, stages 1-3.
// ----------------------------------------------------------------------------
module gno_hash import gno_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  op_type   op0,
   input  wr_type   wr,
   output op_type   op3,
   output hash_type hash,
   output logic     busy
);

   localparam int COPIES = 7;

   op_type op1_ff, op2_ff, op3_ff;
   logic [1:0][ADDR_W-1:0] rd_addr [COPIES];
   logic [1:0][DATA_W-1:0] rd_data [COPIES];
   logic [1:0][DATA_W-1:0] l1_s2_ff, l1_s3_ff;
   logic [3:0][DATA_W-1:0] l2_s3_ff;

   genvar gi;
   generate
      for (gi = 0; gi < COPIES; gi++) begin : g_copy
         gno_hash_ram u_ram (
            .clock   (clock),
            .en      (adv),
            .wr      (wr),
            .rd_addr (rd_addr[gi]),
            .rd_data (rd_data[gi])
         );
      end
   endgenerate

   always_comb begin
      rd_addr[0][0] = op0.ix;
      rd_addr[0][1] = op0.ix + ADDR_W'(1);
      rd_addr[1][0] = rd_data[0][0] + op1_ff.iy;
      rd_addr[1][1] = rd_data[0][0] + op1_ff.iy + ADDR_W'(1);
      rd_addr[2][0] = rd_data[0][1] + op1_ff.iy;
      rd_addr[2][1] = rd_data[0][1] + op1_ff.iy + ADDR_W'(1);
      for (int i = 0; i < 4; i++) begin
         rd_addr[3+i][0] = rd_data[1+i/2][i%2] + op2_ff.iz;
         rd_addr[3+i][1] = rd_data[1+i/2][i%2] + op2_ff.iz + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op1_ff   <= op0;
         op2_ff   <= op1_ff;
         op3_ff   <= op2_ff;
         l1_s2_ff <= rd_data[0];
         l1_s3_ff <= l1_s2_ff;
         l2_s3_ff <= {rd_data[2], rd_data[1]};
      end
      if (reset) begin
         op1_ff.valid <= 1'b0;
         op2_ff.valid <= 1'b0;
         op3_ff.valid <= 1'b0;
      end
   end

   always_comb begin
      hash.h1 = l1_s3_ff;
      hash.h2 = l2_s3_ff;
      hash.h3 = {rd_data[6], rd_data[5], rd_data[4], rd_data[3]};
   end

   assign op3  = op3_ff;
   assign busy = op1_ff.valid || op2_ff.valid;

endmodule

>>> hdl/gno_fade.sv
// ----------------------------------------------------------------------------
// gno_fade
// Fade curve 6t^5-15t^4+10t^3 in three multiply stages.
// ----------------------------------------------------------------------------
module gno_fade import gno_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic [FRAC_BITS-1:0] t,
   output logic [FADE_W-1:0]    f
);

   localparam int AW = FRAC_BITS + 5;
   localparam int BW = FRAC_BITS + 4;

   logic signed [AW-1:0]        a_c, ab_ff;
   logic signed [AW+FADE_W-1:0] p1_c;
   logic [2*FRAC_BITS-1:0]      sq_c, cu_c;
   logic [FRAC_BITS-1:0]        c_ff, t1_ff, d_ff;
   logic [BW-1:0]               b_ff;
   logic [BW+FRAC_BITS-1:0]     fp_c;
   logic [BW-1:0]               fr_c;
   logic [FADE_W-1:0]           f_ff;

   assign a_c  = AW'(32'(t) * 6) - AW'(15 * ONE);
   assign p1_c = a_c * $signed({1'b0, t});
   assign sq_c = t * t;
   assign cu_c = c_ff * t1_ff;
   assign fp_c = b_ff * d_ff;
   assign fr_c = fp_c[FRAC_BITS +: BW];

   always_ff @(posedge clock) begin
      if (en) begin
         ab_ff <= AW'(p1_c >>> FRAC_BITS);
         c_ff  <= sq_c[FRAC_BITS +: FRAC_BITS];
         t1_ff <= t;
         b_ff  <= BW'(ab_ff + AW'(10 * ONE));
         d_ff  <= cu_c[FRAC_BITS +: FRAC_BITS];
         f_ff  <= (32'(fr_c) > ONE) ? FADE_W'(ONE) : fr_c[FADE_W-1:0];
      end
   end

   assign f = f_ff;

endmodule

>>> hdl/gno_blend.sv
// ----------------------------------------------------------------------------
// gno_blend
// Gradients, three lerp levels, octave weighting and the saturating sum.
// Owns the result register and the pipeline advance.
// ----------------------------------------------------------------------------
module gno_blend import gno_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  op_type            op3,
   input  hash_type          hash,
   input  logic [FADE_W-1:0] fu,
   input  logic [FADE_W-1:0] fv,
   input  logic [FADE_W-1:0] fw,
   output logic              adv,
   gno_rsp_if.source         rsp_chan
);

   typedef logic signed [GRAD_W-1:0] val_type;

   function automatic val_type grad1(input logic [DATA_W-1:0] h, input val_type x);
      grad1 = h[0] ? -x : x;
   endfunction

   function automatic val_type grad2(input logic [DATA_W-1:0] h, input val_type x,
                                     input val_type y);
      val_type a, b;
      a = h[1] ? -x : x;
      b = h[0] ? -y : y;
      grad2 = a + b;
   endfunction

   function automatic val_type grad3(input logic [DATA_W-1:0] hash_in, input val_type x,
                                     input val_type y, input val_type z);
      logic [3:0] h;
      val_type    u, v;
      h = hash_in[3:0];
      u = (h < 4'd8) ? x : y;
      v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
      grad3 = (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

   function automatic val_type lerp(input logic [FADE_W-1:0] u, input val_type p,
                                    input val_type q);
      logic signed [GRAD_W:0]          diff;
      logic signed [GRAD_W+FADE_W+1:0] prod;
      diff = (GRAD_W+1)'(q) - (GRAD_W+1)'(p);
      prod = $signed({1'b0, u}) * diff;
      lerp = p + GRAD_W'(prod >>> FRAC_BITS);
   endfunction

   localparam logic signed [OUT_W:0] SUM_HI = (OUT_W+1)'(8 * ONE - 1);
   localparam logic signed [OUT_W:0] SUM_LO = (OUT_W+1)'(-8 * ONE);

   op_type  op4_ff, op5_ff, op6_ff, op7_ff, op8_ff;
   val_type g_c [8];
   val_type g_ff [8];
   val_type l_ff [4];
   val_type m_ff [2];
   val_type n_ff, term_ff;
   logic [FADE_W-1:0] u4_ff, v4_ff, w4_ff, v5_ff, w5_ff, w6_ff;
   logic signed [OUT_W-1:0] acc_ff, rsp_noise_ff;
   logic rsp_valid_ff;

   val_type x_c, y_c, z_c, xm_c, ym_c, zm_c;
   logic [FADE_W-1:0] v_c, w_c;
   logic signed [GRAD_W+AMP_W:0] tp_c;
   logic signed [OUT_W:0] sum_c;
   logic signed [OUT_W-1:0] sat_c;
   logic emit;

   always_comb begin
      x_c  = $signed(GRAD_W'(op3.fx));
      y_c  = $signed(GRAD_W'(op3.fy));
      z_c  = $signed(GRAD_W'(op3.fz));
      xm_c = x_c - GRAD_W'(ONE);
      ym_c = y_c - GRAD_W'(ONE);
      zm_c = z_c - GRAD_W'(ONE);
      for (int i = 0; i < 8; i++) begin
         g_c[i] = '0;
      end
      v_c = '0;
      w_c = '0;
      case (op3.mode)
         MODE_1D: begin
            g_c[0] = grad1(hash.h1[0], x_c);
            g_c[1] = grad1(hash.h1[1], xm_c);
         end
         MODE_2D: begin
            v_c    = fv;
            g_c[0] = grad2(hash.h2[0], x_c,  y_c);
            g_c[1] = grad2(hash.h2[2], xm_c, y_c);
            g_c[2] = grad2(hash.h2[1], x_c,  ym_c);
            g_c[3] = grad2(hash.h2[3], xm_c, ym_c);
         end
         MODE_3D: begin
            v_c    = fv;
            w_c    = fw;
            g_c[0] = grad3(hash.h3[0], x_c,  y_c,  z_c);
            g_c[1] = grad3(hash.h3[4], xm_c, y_c,  z_c);
            g_c[2] = grad3(hash.h3[2], x_c,  ym_c, z_c);
            g_c[3] = grad3(hash.h3[6], xm_c, ym_c, z_c);
            g_c[4] = grad3(hash.h3[1], x_c,  y_c,  zm_c);
            g_c[5] = grad3(hash.h3[5], xm_c, y_c,  zm_c);
            g_c[6] = grad3(hash.h3[3], x_c,  ym_c, zm_c);
            g_c[7] = grad3(hash.h3[7], xm_c, ym_c, zm_c);
         end
         default: ;
      endcase
   end

   assign tp_c = n_ff * $signed({1'b0, op7_ff.amp});

   always_comb begin
      sum_c = (op8_ff.first ? '0 : (OUT_W+1)'(acc_ff)) + (OUT_W+1)'(term_ff);
      if (op8_ff.zero) begin
         sat_c = '0;
      end else if (sum_c > SUM_HI) begin
         sat_c = OUT_W'(SUM_HI);
      end else if (sum_c < SUM_LO) begin
         sat_c = OUT_W'(SUM_LO);
      end else begin
         sat_c = OUT_W'(sum_c);
      end
   end

   assign emit = op8_ff.valid && op8_ff.last;
   assign adv  = !(rsp_valid_ff && !rsp_chan.ready && emit);

   always_ff @(posedge clock) begin
      if (adv) begin
         op4_ff <= op3;
         u4_ff  <= fu;
         v4_ff  <= v_c;
         w4_ff  <= w_c;
         for (int i = 0; i < 8; i++) begin
            g_ff[i] <= g_c[i];
         end
         op5_ff <= op4_ff;
         v5_ff  <= v4_ff;
         w5_ff  <= w4_ff;
         for (int i = 0; i < 4; i++) begin
            l_ff[i] <= lerp(u4_ff, g_ff[2*i], g_ff[2*i+1]);
         end
         op6_ff  <= op5_ff;
         w6_ff   <= w5_ff;
         m_ff[0] <= lerp(v5_ff, l_ff[0], l_ff[1]);
         m_ff[1] <= lerp(v5_ff, l_ff[2], l_ff[3]);
         op7_ff  <= op6_ff;
         n_ff    <= lerp(w6_ff, m_ff[0], m_ff[1]);
         op8_ff  <= op7_ff;
         term_ff <= GRAD_W'(tp_c >>> FRAC_BITS);
         if (op8_ff.valid) begin
            acc_ff <= sat_c;
         end
         if (emit) begin
            rsp_noise_ff <= sat_c;
         end
      end
      if (reset) begin
         op4_ff.valid <= 1'b0;
         op5_ff.valid <= 1'b0;
         op6_ff.valid <= 1'b0;
         op7_ff.valid <= 1'b0;
         op8_ff.valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.noise_value = rsp_noise_ff;

endmodule

>>> hdl/gradient_noise_octaves_top.sv
// ----------------------------------------------------------------------------
// gradient_noise_octaves_top
// Throughput: the octave sequencer issues one octave per cycle while the
// pipeline advances and takes a new request with the last octave of the
// previous one; a table write waits until the sequencer is idle and hash
// stages 1-2 hold no octave. Reset clears the valid bits, sets octave_count
// to 1 and persistence to 32768; the hash table keeps its contents.
// ----------------------------------------------------------------------------
module gradient_noise_octaves_top import gno_pkg::*; #(
   parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   gno_req_if.sink    req_chan,
   gno_rsp_if.source  rsp_chan,
   gno_csr_if.sink    csr_chan
);

   op_type            op0, op3;
   wr_type            wr;
   hash_type          hash;
   logic              adv, busy;
   logic [FADE_W-1:0] fu, fv, fw;

   gno_issue #(
      .MAX_OCTAVES (MAX_OCTAVES)
   ) u_issue (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .busy     (busy),
      .req_chan (req_chan),
      .csr_chan (csr_chan),
      .op0      (op0),
      .wr       (wr)
   );

   gno_hash u_hash (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .op0   (op0),
      .wr    (wr),
      .op3   (op3),
      .hash  (hash),
      .busy  (busy)
   );

   gno_fade u_fade_x (.clock(clock), .en(adv), .t(op0.fx), .f(fu));
   gno_fade u_fade_y (.clock(clock), .en(adv), .t(op0.fy), .f(fv));
   gno_fade u_fade_z (.clock(clock), .en(adv), .t(op0.fz), .f(fw));

   gno_blend u_blend (
      .clock    (clock),
      .reset    (reset),
      .op3      (op3),
      .hash     (hash),
      .fu       (fu),
      .fv       (fv),
      .fw       (fw),
      .adv      (adv),
      .rsp_chan (rsp_chan)
   );

endmodule
